// ===== rtl/sts_pkg.sv =====
// Shared types, token kind codes, byte codes and byte classifiers of the source token scanner.
// Depends on nothing; every other file of the block imports it.
package sts_pkg;

    // Most results that one input word can cause.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;
    localparam int KIND_W  = 5;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [7:0]        byte_t;

    // Token kinds.
    localparam kind_t KIND_COMMA    = 5'd0;
    localparam kind_t KIND_DOT      = 5'd1;
    localparam kind_t KIND_COLON    = 5'd2;
    localparam kind_t KIND_SEMI     = 5'd3;
    localparam kind_t KIND_LPAREN   = 5'd4;
    localparam kind_t KIND_RPAREN   = 5'd5;
    localparam kind_t KIND_LBRACE   = 5'd6;
    localparam kind_t KIND_RBRACE   = 5'd7;
    localparam kind_t KIND_LBRACKET = 5'd8;
    localparam kind_t KIND_RBRACKET = 5'd9;
    localparam kind_t KIND_STAR     = 5'd10;
    localparam kind_t KIND_CARET    = 5'd11;
    localparam kind_t KIND_PERCENT  = 5'd12;
    localparam kind_t KIND_INCR     = 5'd13;
    localparam kind_t KIND_PLUS     = 5'd14;
    localparam kind_t KIND_DECR     = 5'd15;
    localparam kind_t KIND_MINUS    = 5'd16;
    localparam kind_t KIND_LAND     = 5'd17;
    localparam kind_t KIND_LOR      = 5'd18;
    localparam kind_t KIND_NE       = 5'd19;
    localparam kind_t KIND_NOT      = 5'd20;
    localparam kind_t KIND_EQ       = 5'd21;
    localparam kind_t KIND_ASSIGN   = 5'd22;
    localparam kind_t KIND_GE       = 5'd23;
    localparam kind_t KIND_GT       = 5'd24;
    localparam kind_t KIND_LE       = 5'd25;
    localparam kind_t KIND_LT       = 5'd26;
    localparam kind_t KIND_SLASH    = 5'd27;
    localparam kind_t KIND_NUMBER   = 5'd28;
    localparam kind_t KIND_ERROR    = 5'd29;
    localparam kind_t KIND_END      = 5'd30;
    // Marks "no token" inside the classifiers; never leaves the block.
    localparam kind_t KIND_NONE     = 5'd31;

    // Source byte codes.
    localparam byte_t CH_NUL    = 8'h00;
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_BANG   = 8'h21;
    localparam byte_t CH_PCT    = 8'h25;
    localparam byte_t CH_AMP    = 8'h26;
    localparam byte_t CH_LPAREN = 8'h28;
    localparam byte_t CH_RPAREN = 8'h29;
    localparam byte_t CH_STAR   = 8'h2A;
    localparam byte_t CH_PLUS   = 8'h2B;
    localparam byte_t CH_COMMA  = 8'h2C;
    localparam byte_t CH_MINUS  = 8'h2D;
    localparam byte_t CH_DOT    = 8'h2E;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_NINE   = 8'h39;
    localparam byte_t CH_COLON  = 8'h3A;
    localparam byte_t CH_SEMI   = 8'h3B;
    localparam byte_t CH_LT     = 8'h3C;
    localparam byte_t CH_EQ     = 8'h3D;
    localparam byte_t CH_GT     = 8'h3E;
    localparam byte_t CH_LBRACK = 8'h5B;
    localparam byte_t CH_RBRACK = 8'h5D;
    localparam byte_t CH_CARET  = 8'h5E;
    localparam byte_t CH_LBRACE = 8'h7B;
    localparam byte_t CH_BAR    = 8'h7C;
    localparam byte_t CH_RBRACE = 8'h7D;

    // Scanner modes, one-hot.
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_HOLD    = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_NUM     = 5'b01000,
        MODE_NUMDOT  = 5'b10000
    } scan_mode_t;

    // Hand-over of one accepted word's results from the scanner to the result queue.
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } burst_ctl_t;

    function automatic logic is_digit(input byte_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_op_start(input byte_t c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_AMP) || (c == CH_BAR) ||
               (c == CH_BANG) || (c == CH_EQ) || (c == CH_GT) || (c == CH_LT) ||
               (c == CH_SLASH);
    endfunction

    // One-byte punctuation tokens.
    function automatic kind_t punct_kind(input byte_t c);
        kind_t k;
        unique case (c)
            CH_COMMA:  k = KIND_COMMA;
            CH_DOT:    k = KIND_DOT;
            CH_COLON:  k = KIND_COLON;
            CH_SEMI:   k = KIND_SEMI;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LBRACK: k = KIND_LBRACKET;
            CH_RBRACK: k = KIND_RBRACKET;
            CH_STAR:   k = KIND_STAR;
            CH_CARET:  k = KIND_CARET;
            CH_PCT:    k = KIND_PERCENT;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Two-byte operators formed by the held byte and the new one.
    function automatic kind_t pair_kind(input byte_t a, input byte_t b);
        kind_t k;
        k = KIND_NONE;
        if (a == CH_PLUS && b == CH_PLUS) begin
            k = KIND_INCR;
        end else if (a == CH_MINUS && b == CH_MINUS) begin
            k = KIND_DECR;
        end else if (a == CH_AMP && b == CH_AMP) begin
            k = KIND_LAND;
        end else if (a == CH_BAR && b == CH_BAR) begin
            k = KIND_LOR;
        end else if (b == CH_EQ) begin
            if (a == CH_BANG) begin
                k = KIND_NE;
            end else if (a == CH_EQ) begin
                k = KIND_EQ;
            end else if (a == CH_GT) begin
                k = KIND_GE;
            end else if (a == CH_LT) begin
                k = KIND_LE;
            end
        end
        return k;
    endfunction

    // A held operator byte standing alone; a lone ampersand or bar gives no token.
    function automatic kind_t single_kind(input byte_t a);
        kind_t k;
        unique case (a)
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_BANG:  k = KIND_NOT;
            CH_EQ:    k = KIND_ASSIGN;
            CH_GT:    k = KIND_GT;
            CH_LT:    k = KIND_LT;
            CH_SLASH: k = KIND_SLASH;
            default:  k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/source_token_scanner_top.sv =====
// Top level of the source token scanner: stream ports, scanner core and result queue.
// Depends on sts_pkg, sts_scan_core and sts_result_queue.
//
//   Port group  Direction  Word contents
//   s_*         in         tdata[7:0] ch; tlast final_byte
//   m_*         out        tdata token_kind, line_number, start_offset, end_offset; tlast run_last
//
// One source byte is accepted per cycle while each byte yields at most one token and the
// output does not stall; a byte with more tokens holds the input until the one-token-a-cycle
// output register takes all but its last. Each token passes the burst buffer and the output register.
// Reset is synchronous on aresetn low and returns line 1, offset 0 and an idle scanner.
// A stall on m_tready stops the input once the output register is full and a burst token waits.
module source_token_scanner_top
    import sts_pkg::*;
#(
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_kind, line_number, start_offset, end_offset from bit 0 up, zero padded to bytes
    output logic [((KIND_W + LINE_BITS + 2 * OFFSET_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tlast
);

    localparam int REC_W   = KIND_W + LINE_BITS + 2 * OFFSET_BITS;
    localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

    logic                          accept;
    burst_ctl_t                    ctl;
    logic [MAX_RES-1:0][REC_W-1:0] recs;
    logic [REC_W-1:0]              out_rec;

    assign accept = s_tvalid && s_tready;

    sts_scan_core #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .REC_W       (REC_W)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .ch         (s_tdata),
        .final_byte (s_tlast),
        .ctl        (ctl),
        .recs       (recs)
    );

    sts_result_queue #(
        .REC_W (REC_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .recs      (recs),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec),
        .out_last  (m_tlast)
    );

    assign m_tdata = TDATA_W'(out_rec);

endmodule

// ===== rtl/sts_scan_core.sv =====
// Scanner state registers and the single-pass decision logic for one source byte.
// Depends on sts_pkg; hands up to four packed token records to sts_result_queue.
module sts_scan_core
    import sts_pkg::*;
#(
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 24,
    parameter int REC_W       = KIND_W + LINE_BITS + 2 * OFFSET_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  byte_t                       ch,
    input  logic                        final_byte,
    output burst_ctl_t                  ctl,
    output logic [MAX_RES-1:0][REC_W-1:0] recs
);

    localparam int                   NCAND    = 6;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    // Candidate slots in output order: operator or number close, the dot after a
    // number, a fresh punctuation token, the flush at end of input (two slots), end token.
    localparam int C_FIRST = 0;
    localparam int C_DOT   = 1;
    localparam int C_FRESH = 2;
    localparam int C_FLUSH = 3;
    localparam int C_FDOT  = 4;
    localparam int C_END   = 5;

    scan_mode_t             mode_reg,   mode_next;
    byte_t                  held_reg,   held_next;
    logic [LINE_BITS-1:0]   line_reg,   line_next;
    logic [OFFSET_BITS-1:0] boff_reg,   boff_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [LINE_BITS-1:0]   tline_reg,  tline_next;
    logic [1:0]             dots_reg,   dots_next;

    logic [NCAND-1:0]            cand_v;
    logic [NCAND-1:0][REC_W-1:0] cand_rec;

    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] off_dec(input logic [OFFSET_BITS-1:0] v);
        return (v == '0) ? v : v - OFFSET_BITS'(1);
    endfunction

    function automatic logic [REC_W-1:0] mk_rec(input kind_t k,
                                                input logic [LINE_BITS-1:0] ln,
                                                input logic [OFFSET_BITS-1:0] s,
                                                input logic [OFFSET_BITS-1:0] e);
        return {e, s, ln, k};
    endfunction

    // Decision logic for one byte, then the end-of-input flush.
    always_comb begin
        scan_mode_t             md;
        byte_t                  hb;
        logic [LINE_BITS-1:0]   lc;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] pos_inc;
        logic [OFFSET_BITS-1:0] dp;
        logic [OFFSET_BITS-1:0] bo;
        logic [OFFSET_BITS-1:0] ts;
        logic [LINE_BITS-1:0]   tl;
        logic [1:0]             ds;
        logic                   do_fresh;
        kind_t                  k;
        kind_t                  num_k;

        md       = mode_reg;
        hb       = held_reg;
        lc       = line_reg;
        bo       = boff_reg;
        ts       = tstart_reg;
        tl       = tline_reg;
        ds       = dots_reg;
        pos      = boff_reg;
        pos_inc  = off_inc(boff_reg);
        dp       = off_dec(boff_reg);
        do_fresh = 1'b0;
        k        = KIND_NONE;
        num_k    = (dots_reg >= 2'd2) ? KIND_ERROR : KIND_NUMBER;
        cand_v   = '0;
        cand_rec = '0;

        if (ch != CH_NUL) begin
            // Continue the token in progress.
            unique case (mode_reg)
                MODE_HOLD: begin
                    k = pair_kind(held_reg, ch);
                    if (k != KIND_NONE) begin
                        cand_v[C_FIRST]   = 1'b1;
                        cand_rec[C_FIRST] = mk_rec(k, tline_reg, tstart_reg, pos_inc);
                        md = MODE_IDLE;
                    end else if (held_reg == CH_SLASH && ch == CH_SLASH) begin
                        md = MODE_COMMENT;
                    end else begin
                        k = single_kind(held_reg);
                        cand_v[C_FIRST]   = (k != KIND_NONE);
                        cand_rec[C_FIRST] = mk_rec(k, tline_reg, tstart_reg,
                                                   off_inc(tstart_reg));
                        md       = MODE_IDLE;
                        do_fresh = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (ch == CH_LF) begin
                        lc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;
                        md = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    if (ch == CH_DOT) begin
                        md = MODE_NUMDOT;
                    end else if (!is_digit(ch)) begin
                        cand_v[C_FIRST]   = 1'b1;
                        cand_rec[C_FIRST] = mk_rec(num_k, tline_reg, tstart_reg, pos);
                        md       = MODE_IDLE;
                        do_fresh = 1'b1;
                    end
                end
                MODE_NUMDOT: begin
                    if (is_digit(ch)) begin
                        ds = (dots_reg >= 2'd2) ? dots_reg : dots_reg + 2'd1;
                        md = MODE_NUM;
                    end else begin
                        // The dot did not continue the number: close it before the dot.
                        cand_v[C_FIRST]   = 1'b1;
                        cand_rec[C_FIRST] = mk_rec(num_k, tline_reg, tstart_reg, dp);
                        cand_v[C_DOT]     = 1'b1;
                        cand_rec[C_DOT]   = mk_rec(KIND_DOT, line_reg, dp, pos);
                        md       = MODE_IDLE;
                        do_fresh = 1'b1;
                    end
                end
                default: begin
                    md       = MODE_IDLE;
                    do_fresh = 1'b1;
                end
            endcase

            // Start of a new token from this byte.
            if (do_fresh) begin
                k = punct_kind(ch);
                if (k != KIND_NONE) begin
                    cand_v[C_FRESH]   = 1'b1;
                    cand_rec[C_FRESH] = mk_rec(k, line_reg, pos, pos_inc);
                end else if (ch == CH_LF) begin
                    lc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;
                end else if (is_op_start(ch)) begin
                    hb = ch;
                    ts = pos;
                    tl = line_reg;
                    md = MODE_HOLD;
                end else if (is_digit(ch)) begin
                    ts = pos;
                    tl = line_reg;
                    ds = 2'd0;
                    md = MODE_NUM;
                end
            end
            bo = pos_inc;
        end

        // End of input: flush the pending token and add the end token.
        if (final_byte) begin
            num_k = (ds >= 2'd2) ? KIND_ERROR : KIND_NUMBER;
            if (md == MODE_HOLD) begin
                k = single_kind(hb);
                cand_v[C_FLUSH]   = (k != KIND_NONE);
                cand_rec[C_FLUSH] = mk_rec(k, tl, ts, off_inc(ts));
            end else if (md == MODE_NUM) begin
                cand_v[C_FLUSH]   = 1'b1;
                cand_rec[C_FLUSH] = mk_rec(num_k, tl, ts, bo);
            end else if (md == MODE_NUMDOT) begin
                cand_v[C_FLUSH]   = 1'b1;
                cand_rec[C_FLUSH] = mk_rec(num_k, tl, ts, off_dec(bo));
                cand_v[C_FDOT]    = 1'b1;
                cand_rec[C_FDOT]  = mk_rec(KIND_DOT, lc, off_dec(bo), bo);
            end
            cand_v[C_END]   = 1'b1;
            cand_rec[C_END] = mk_rec(KIND_END, lc, bo, bo);

            mode_next   = MODE_IDLE;
            held_next   = '0;
            line_next   = LINE_ONE;
            boff_next   = '0;
            tstart_next = '0;
            tline_next  = LINE_ONE;
            dots_next   = '0;
        end else begin
            mode_next   = md;
            held_next   = hb;
            line_next   = lc;
            boff_next   = bo;
            tstart_next = ts;
            tline_next  = tl;
            dots_next   = ds;
        end
    end

    // Pack the valid candidates into consecutive result slots.
    always_comb begin
        logic [CNT_W-1:0] n;
        n    = '0;
        recs = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cand_v[i] && n < CNT_W'(MAX_RES)) begin
                recs[n[1:0]] = cand_rec[i];
                n            = n + CNT_W'(1);
            end
        end
        ctl.load  = accept;
        ctl.count = n;
    end

    // Scanner state advances once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= '0;
            line_reg   <= LINE_ONE;
            boff_reg   <= '0;
            tstart_reg <= '0;
            tline_reg  <= LINE_ONE;
            dots_reg   <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            line_reg   <= line_next;
            boff_reg   <= boff_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            dots_reg   <= dots_next;
        end
    end

    // A held byte is always an operator's first byte.
    a_hold_is_op: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HOLD |-> is_op_start(held_reg))
        else $error("held byte is not an operator start");

    // No word ever produces more tokens than the result queue can take.
    a_cand_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> $countones(cand_v) <= MAX_RES)
        else $error("more tokens than result slots");

    // The end of input returns the scanner to its starting state.
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && final_byte |=> mode_reg == MODE_IDLE && line_reg == LINE_ONE &&
                                 boff_reg == '0 && dots_reg == '0)
        else $error("scanner state not cleared after the last byte");

endmodule

// ===== rtl/sts_result_queue.sv =====
// Result burst buffer and output register: holds a word's tokens, sends one a cycle unless stalled.
// Depends on sts_pkg; fed by sts_scan_core.
module sts_result_queue
    import sts_pkg::*;
#(
    parameter int REC_W = 77
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  burst_ctl_t                    ctl,
    input  logic [MAX_RES-1:0][REC_W-1:0] recs,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [REC_W-1:0]              out_rec,
    output logic                          out_last
);

    logic [MAX_RES-1:0][REC_W-1:0] slot_reg;
    logic [CNT_W-1:0]              rem_reg;
    logic                          out_valid_reg;
    logic [REC_W-1:0]              out_rec_reg;
    logic                          out_last_reg;
    logic                          pop;

    // Move the head token into the output register whenever that register frees up.
    assign pop      = (rem_reg != '0) && (!out_valid_reg || out_ready);
    assign in_ready = (rem_reg == '0) || (rem_reg == CNT_W'(1) && pop);

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;
    assign out_last  = out_last_reg;

    // Burst slots: a new word loads them, otherwise they shift towards the head.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            slot_reg <= recs;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    // Count of tokens still waiting in the burst slots.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (ctl.load) begin
            rem_reg <= ctl.count;
        end else if (pop) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    // Output register; the last token of a word carries the run marker.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_rec_reg  <= slot_reg[0];
            out_last_reg <= (rem_reg == CNT_W'(1));
        end
    end

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= CNT_W'(MAX_RES))
        else $error("burst count beyond slot count");

    // A new burst only lands once the previous one is all but gone.
    a_load_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |-> rem_reg == '0 || (rem_reg == CNT_W'(1) && pop))
        else $error("burst overwritten before it drained");

    // A word without tokens leaves nothing waiting.
    a_empty_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load && ctl.count == '0 |=> rem_reg == '0)
        else $error("empty burst left tokens pending");

endmodule
